// ===== hdl/picp_pkg.sv =====
// shared types for the point in convex polygon test
`timescale 1ns / 1ps

package picp_pkg;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    typedef struct packed {
        logic first;
        logic last;
    } slot_t;

endpackage

// ===== hdl/point_in_convex_polygon_top.sv =====
// point in convex polygon test: vertex table and edge sign sequencer
// load: result strobe in the cycle after the accepting edge, next beat may follow at once
// query with n stored vertices: result once the edge pipeline drains, busy until then
// one edge per cycle through the shared difference, multiply and sign pipeline
// query on an empty table answers in the next cycle without going busy
// async reset empties the table and idles the sequencer; the receiver cannot stall
`timescale 1ns / 1ps

module point_in_convex_polygon_top
    import picp_pkg::*;
#(
    parameter int MAX_VERTICES = 32,
    parameter int COORD_BITS   = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         mode,
    input  logic                         restart,
    input  logic signed [COORD_BITS-1:0] x,
    input  logic signed [COORD_BITS-1:0] y,
    output logic                         done,
    output logic                         was_query,
    output logic                         inside_res,
    output logic                         overflow
);

    localparam int CW    = COORD_BITS;
    localparam int DW    = CW + 1;
    localparam int PW    = 2 * DW;
    localparam int SW    = PW + 1;
    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);

    logic signed [CW-1:0] mem_x [MAX_VERTICES];
    logic signed [CW-1:0] mem_y [MAX_VERTICES];

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic signed [CW-1:0] px_reg, py_reg;

    logic accept, ld_accept, q_accept;
    logic [CNT_W-1:0] ld_base;
    logic ld_fits;

    logic  issue, wrap;
    slot_t issue_tag;

    logic  s1_valid_reg;
    slot_t s1_tag_reg;
    logic signed [CW-1:0] rd_x_reg, rd_y_reg;
    logic signed [CW-1:0] v0_x_reg, v0_y_reg, prev_x_reg, prev_y_reg;
    logic signed [CW-1:0] cur_x, cur_y;

    logic s2_valid_reg, s2_last_reg;
    logic signed [DW-1:0] a_reg, b_reg, dx_reg, dy_reg;

    logic s3_valid_reg, s3_last_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;
    logic signed [SW-1:0] d_sum;
    logic d_pos, d_neg;
    logic seen_pos_reg, seen_neg_reg;

    logic done_reg, was_query_reg, inside_reg, overflow_reg;

    assign accept    = start && !busy;
    assign ld_accept = accept && !mode;
    assign q_accept  = accept && mode;
    assign ld_base   = restart ? '0 : cnt_reg;
    assign ld_fits   = ld_base < MAX_CNT;

    assign busy = (state_reg != ST_IDLE);

    // slot n closes the polygon from the last vertex back to vertex 0
    assign issue           = (state_reg == ST_ISSUE);
    assign wrap            = (rd_idx_reg == cnt_reg);
    assign issue_tag.first = (rd_idx_reg == '0);
    assign issue_tag.last  = wrap;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_accept && (cnt_reg != '0))
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (wrap)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (s3_valid_reg && s3_last_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // vertex table
    always_ff @(posedge clk)
    begin
        if (ld_accept && ld_fits)
        begin
            mem_x[ld_base[IDX_W-1:0]] <= x;
            mem_y[ld_base[IDX_W-1:0]] <= y;
        end
        if (issue && !wrap)
        begin
            rd_x_reg <= mem_x[rd_idx_reg[IDX_W-1:0]];
            rd_y_reg <= mem_y[rd_idx_reg[IDX_W-1:0]];
        end
    end

    assign cur_x = s1_tag_reg.last ? v0_x_reg : rd_x_reg;
    assign cur_y = s1_tag_reg.last ? v0_y_reg : rd_y_reg;

    assign d_sum = SW'(p1_reg) + SW'(p2_reg);
    assign d_neg = d_sum[SW-1];
    assign d_pos = !d_sum[SW-1] && (d_sum != '0);

    // datapath payload
    always_ff @(posedge clk)
    begin
        if (q_accept)
        begin
            px_reg <= x;
            py_reg <= y;
        end
        if (issue)
        begin
            s1_tag_reg <= issue_tag;
        end
        if (s1_valid_reg)
        begin
            if (s1_tag_reg.first)
            begin
                v0_x_reg <= cur_x;
                v0_y_reg <= cur_y;
            end
            prev_x_reg  <= cur_x;
            prev_y_reg  <= cur_y;
            s2_last_reg <= s1_tag_reg.last;
            a_reg       <= $signed({prev_x_reg[CW-1], prev_x_reg}) - $signed({cur_x[CW-1], cur_x});
            b_reg       <= $signed({cur_y[CW-1], cur_y}) - $signed({prev_y_reg[CW-1], prev_y_reg});
            dx_reg      <= $signed({px_reg[CW-1], px_reg}) - $signed({prev_x_reg[CW-1], prev_x_reg});
            dy_reg      <= $signed({py_reg[CW-1], py_reg}) - $signed({prev_y_reg[CW-1], prev_y_reg});
        end
        if (s2_valid_reg)
        begin
            s3_last_reg <= s2_last_reg;
            p1_reg      <= PW'(a_reg) * PW'(dy_reg);
            p2_reg      <= PW'(b_reg) * PW'(dx_reg);
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            seen_pos_reg  <= 1'b0;
            seen_neg_reg  <= 1'b0;
            done_reg      <= 1'b0;
            was_query_reg <= 1'b0;
            inside_reg    <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg && !s1_tag_reg.first;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= 1'b0;

            if (issue)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end

            if (ld_accept)
            begin
                cnt_reg       <= ld_fits ? ld_base + 1'b1 : ld_base;
                done_reg      <= 1'b1;
                was_query_reg <= 1'b0;
                inside_reg    <= 1'b0;
                overflow_reg  <= !ld_fits;
            end

            if (q_accept)
            begin
                rd_idx_reg   <= '0;
                seen_pos_reg <= 1'b0;
                seen_neg_reg <= 1'b0;
                if (cnt_reg == '0)
                begin
                    done_reg      <= 1'b1;
                    was_query_reg <= 1'b1;
                    inside_reg    <= 1'b1;
                    overflow_reg  <= 1'b0;
                end
            end

            // inside unless both edge signs occur
            if (s3_valid_reg)
            begin
                seen_pos_reg <= seen_pos_reg || d_pos;
                seen_neg_reg <= seen_neg_reg || d_neg;
                if (s3_last_reg)
                begin
                    done_reg      <= 1'b1;
                    was_query_reg <= 1'b1;
                    inside_reg    <= !((seen_pos_reg || d_pos) && (seen_neg_reg || d_neg));
                    overflow_reg  <= 1'b0;
                end
            end
        end
    end

    assign done       = done_reg;
    assign was_query  = was_query_reg;
    assign inside_res = inside_reg;
    assign overflow   = overflow_reg;

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(busy)))
        else $error("result beat without a pending item");

    a_ovf_load: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |-> !was_query)
        else $error("overflow flagged on a query result");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_CNT)
        else $error("vertex count beyond table size");

    a_pipe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg || s2_valid_reg || s3_valid_reg) |-> busy)
        else $error("edge pipeline active while idle");

endmodule

// ===== bench/point_in_convex_polygon_top_test.sv =====
// self-checking bench for the point in convex polygon block: vertex loads, point queries
`timescale 1ns / 1ps

module point_in_convex_polygon_top_test;

    localparam int   COORD_W     = 16;
    localparam int   TABLE_DEPTH = 32;
    localparam int   TARGET_BEATS = 450;
    localparam int   CALM_TAIL   = 60;
    localparam int   DRAIN_CYCLES = 50;
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;
    localparam real  TWO_PI      = 6.283185307179586;

    typedef struct packed {
        logic                      mode;
        logic                      restart;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } poly_beat_t;

    typedef struct packed {
        logic was_query;
        logic inside_res;
        logic overflow;
    } answer_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      mode = MODE_LOAD;
    logic                      restart = 1'b0;
    logic signed [COORD_W-1:0] x = '0;
    logic signed [COORD_W-1:0] y = '0;
    logic                      busy;
    logic                      done;
    logic                      was_query;
    logic                      inside_res;
    logic                      overflow;

    poly_beat_t pending_beats[$];
    answer_t    answers_due[$];
    poly_beat_t cur_beat;
    int         gap_left = 0;
    int         quiet_left = 0;
    int         mismatches = 0;

    logic signed [COORD_W-1:0] vtx_x[TABLE_DEPTH];
    logic signed [COORD_W-1:0] vtx_y[TABLE_DEPTH];
    int                        vtx_count = 0;

    point_in_convex_polygon_top #(
        .MAX_VERTICES(TABLE_DEPTH),
        .COORD_BITS  (COORD_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (mode),
        .restart   (restart),
        .x         (x),
        .y         (y),
        .done      (done),
        .was_query (was_query),
        .inside_res(inside_res),
        .overflow  (overflow)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // updates the vertex table on a load and returns the answer the block owes for this beat
    function automatic answer_t predict_answer(poly_beat_t b);
        answer_t ans;
        int      run;
        int      s;
        int      j;
        longint  a;
        longint  bb;
        longint  d;
        ans = '0;
        if (b.mode == MODE_QUERY)
        begin
            ans.was_query = 1'b1;
            ans.inside_res = 1'b1;
            run = 0;
            for (int i = 0; i < vtx_count; i++)
            begin
                j = (i + 1 < vtx_count) ? i + 1 : 0;
                a = longint'(vtx_x[i]) - longint'(vtx_x[j]);
                bb = longint'(vtx_y[j]) - longint'(vtx_y[i]);
                d = a * (longint'(b.y) - longint'(vtx_y[i]))
                    + bb * (longint'(b.x) - longint'(vtx_x[i]));
                s = (d < 0) ? -1 : ((d > 0) ? 1 : 0);
                if (s == 0)
                    s = run;
                if (run == 0 && s != 0)
                    run = s;
                else if (s != run)
                begin
                    ans.inside_res = 1'b0;
                    break;
                end
            end
        end
        else
        begin
            if (b.restart)
                vtx_count = 0;
            if (vtx_count < TABLE_DEPTH)
            begin
                vtx_x[vtx_count] = b.x;
                vtx_y[vtx_count] = b.y;
                vtx_count++;
            end
            else
                ans.overflow = 1'b1;
        end
        return ans;
    endfunction

    task automatic add_beat(logic m, logic rs, int xv, int yv);
        poly_beat_t b;
        b.mode = m;
        b.restart = rs;
        b.x = xv[COORD_W-1:0];
        b.y = yv[COORD_W-1:0];
        pending_beats.push_back(b);
    endtask

    task automatic add_noise_beat();
        add_beat(1'($urandom()), 1'($urandom()), int'($urandom()), int'($urandom()));
    endtask

    // one convex polygon loaded vertex by vertex, then a batch of queries against it, with random noise beats mixed in
    task automatic add_polygon_set(bit full_table);
        int  n;
        int  cx;
        int  cy;
        int  r;
        int  nq;
        int  k;
        int  kn;
        int  sx[TABLE_DEPTH];
        int  sy[TABLE_DEPTH];
        real phase;
        real ang;
        bit  cw;
        if (full_table)
            n = TABLE_DEPTH;
        else if ($urandom_range(0, 9) == 0)
            n = $urandom_range(1, 2);
        else
            n = $urandom_range(3, 8);
        cx = $urandom_range(0, 40000) - 20000;
        cy = $urandom_range(0, 40000) - 20000;
        r = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 60) : $urandom_range(61, 9000);
        phase = $urandom_range(0, 9999) / 10000.0 * TWO_PI;
        cw = 1'($urandom());
        for (int i = 0; i < n; i++)
        begin
            ang = phase + (cw ? -1.0 : 1.0) * TWO_PI * i / n;
            sx[i] = cx + $rtoi(r * $cos(ang));
            sy[i] = cy + $rtoi(r * $sin(ang));
            add_beat(MODE_LOAD, (i == 0) ? 1'b1 : 1'b0, sx[i], sy[i]);
            if ($urandom_range(0, 29) == 0)
                add_noise_beat();
        end
        if (full_table)
            for (int i = $urandom_range(1, 3); i > 0; i--)
                add_beat(MODE_LOAD, 1'b0, int'($urandom()), int'($urandom()));
        nq = $urandom_range(3, 8);
        for (int q = 0; q < nq; q++)
        begin
            k = $urandom_range(0, n - 1);
            kn = (k + 1 < n) ? k + 1 : 0;
            case ($urandom_range(0, 5))
                0:       add_beat(MODE_QUERY, 1'($urandom()), sx[k], sy[k]);
                1:       add_beat(MODE_QUERY, 1'($urandom()),
                                  (sx[k] + sx[kn]) / 2, (sy[k] + sy[kn]) / 2);
                2:       add_beat(MODE_QUERY, 1'($urandom()), int'($urandom()), int'($urandom()));
                default: add_beat(MODE_QUERY, 1'($urandom()),
                                  cx + $urandom_range(0, 2 * r + r / 2) - r - r / 4,
                                  cy + $urandom_range(0, 2 * r + r / 2) - r - r / 4);
            endcase
        end
        if ($urandom_range(0, 4) == 0)
            add_noise_beat();
    endtask

    task automatic note_failure(string msg);
        if (mismatches < 10)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // driver: one beat offered at a time, held until the block takes it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                answers_due.push_back(predict_answer(cur_beat));
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_beats.size() > CALM_TAIL && quiet_left == 0
                         && $urandom_range(0, 5) == 0)
                begin
                    gap_left = $urandom_range(0, 8);
                    start <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    cur_beat = pending_beats.pop_front();
                    start <= 1'b1;
                    mode <= cur_beat.mode;
                    restart <= cur_beat.restart;
                    x <= cur_beat.x;
                    y <= cur_beat.y;
                    if (quiet_left > 0)
                        quiet_left--;
                    else if ($urandom_range(0, 39) == 0)
                        quiet_left = $urandom_range(20, 60);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: every strobed result against the oldest pending answer
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && done)
        begin
            if (answers_due.size() == 0)
                note_failure($sformatf("unexpected beat was_query=%0b inside_res=%0b overflow=%0b",
                                       was_query, inside_res, overflow));
            else
            begin
                want = answers_due.pop_front();
                if (want.was_query !== was_query || want.inside_res !== inside_res
                    || want.overflow !== overflow)
                    note_failure($sformatf({"expected was_query=%0b inside_res=%0b overflow=%0b,",
                                            " got %0b %0b %0b"},
                                           want.was_query, want.inside_res, want.overflow,
                                           was_query, inside_res, overflow));
            end
        end
    end

    initial
    begin
        int set_no;
        // empty table, restart flag on a query
        add_beat(MODE_QUERY, 1'b0, 0, 0);
        add_beat(MODE_QUERY, 1'b1, 32767, -32768);
        // single vertex
        add_beat(MODE_LOAD, 1'b1, 100, 100);
        add_beat(MODE_QUERY, 1'b0, 5000, -3000);
        // two vertices: only the supporting line answers inside
        add_beat(MODE_LOAD, 1'b0, 300, 300);
        add_beat(MODE_QUERY, 1'b0, 200, 200);
        add_beat(MODE_QUERY, 1'b0, 1000, 1000);
        add_beat(MODE_QUERY, 1'b0, 0, 50);
        // triangle spanning the full coordinate range
        add_beat(MODE_LOAD, 1'b1, -32768, -32768);
        add_beat(MODE_LOAD, 1'b0, 32767, -32768);
        add_beat(MODE_LOAD, 1'b0, 0, 32767);
        add_beat(MODE_QUERY, 1'b0, 0, 0);
        add_beat(MODE_QUERY, 1'b0, -32768, -32768);
        add_beat(MODE_QUERY, 1'b0, 0, -32768);
        add_beat(MODE_QUERY, 1'b0, 32767, 32767);
        add_beat(MODE_QUERY, 1'b1, -32768, 32767);
        // clockwise square
        add_beat(MODE_LOAD, 1'b1, -10, -10);
        add_beat(MODE_LOAD, 1'b0, -10, 10);
        add_beat(MODE_LOAD, 1'b0, 10, 10);
        add_beat(MODE_LOAD, 1'b0, 10, -10);
        add_beat(MODE_QUERY, 1'b0, 0, 0);
        add_beat(MODE_QUERY, 1'b0, 10, 0);
        add_beat(MODE_QUERY, 1'b0, 11, 0);
        set_no = 0;
        while (pending_beats.size() < TARGET_BEATS)
        begin
            add_polygon_set(set_no % 9 == 0);
            set_no++;
        end

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() != 0 || start || answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/picp_pkg.sv
hdl/point_in_convex_polygon_top.sv
bench/point_in_convex_polygon_top_test.sv
